/* rtl/assert_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks on the peak meter.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check in normal operation, off while reset is asserted.
`define PMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define PMR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pmr_pkg.sv */
// -----------------------------------------------------------------------------
// pmr_pkg
// Types and constants shared by the peak meter modules.
// -----------------------------------------------------------------------------
`default_nettype none

package pmr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int LEVEL_W     = 24;
  localparam int DECAY_W     = 25;
  localparam int FRAC_W      = 24;
  localparam int MASK_W      = 16;
  localparam int SLOT_W      = 4;
  localparam int PCH_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 25;

  localparam logic [DECAY_W-1:0] ONE_Q24     = 25'h1000000;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 25'd16773412;
  localparam logic [LEVEL_W-1:0] FULL_SCALE  = 24'h800000;

  // input word layout
  localparam int IN_TDATA_W  = 40;
  localparam int IN_SLOT_LSB = 0;
  localparam int IN_SMP_LSB  = IN_SLOT_LSB + SLOT_W;
  localparam int IN_PCH_LSB  = IN_SMP_LSB + SAMPLE_BITS;

  // output word layout
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_CH_LSB  = 0;
  localparam int OUT_LVL_LSB = OUT_CH_LSB + PCH_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - PCH_W - LEVEL_W;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY       = 2'd1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_MUL1,
    S_MUL2,
    S_RD,
    S_RDOUT
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } lvl_ctl_t;

endpackage

`default_nettype wire

/* rtl/pmr_mul.sv */
// -----------------------------------------------------------------------------
// pmr_mul
// Shared Q1.24 multiplier with registered, truncated product.
// -----------------------------------------------------------------------------
`default_nettype none

module pmr_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [pmr_pkg::DECAY_W-1:0] a,
  input  logic [pmr_pkg::DECAY_W-1:0] b,
  output logic [pmr_pkg::DECAY_W-1:0] q
);
  import pmr_pkg::*;

  logic [2*DECAY_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {{DECAY_W{1'b0}}, a} * {{DECAY_W{1'b0}}, b};
    end
  end

  assign q = prod_r[FRAC_W +: DECAY_W];

endmodule

`default_nettype wire

/* rtl/pmr_slot_map.sv */
// -----------------------------------------------------------------------------
// pmr_slot_map
// Map an active slot to the physical channel of the matching set mask bit.
// -----------------------------------------------------------------------------
`default_nettype none

module pmr_slot_map #(
  parameter int LIMIT = 16
) (
  input  logic [pmr_pkg::MASK_W-1:0] mask,
  input  logic [pmr_pkg::SLOT_W-1:0] slot,
  output logic                       hit,
  output logic [pmr_pkg::SLOT_W-1:0] ch
);
  import pmr_pkg::*;

  logic [MASK_W-1:0] match;

  always_comb begin
    for (int c = 0; c < MASK_W; c++) begin
      match[c] = (c < LIMIT) && mask[c] &&
                 ($countones(mask & MASK_W'((1 << c) - 1)) == int'(slot));
    end
  end

  always_comb begin
    ch = '0;
    for (int c = 0; c < MASK_W; c++) begin
      if (match[c]) begin
        ch = SLOT_W'(c);
      end
    end
  end

  assign hit = |match;

endmodule

`default_nettype wire

/* rtl/pmr_level_mem.sv */
// -----------------------------------------------------------------------------
// pmr_level_mem
// Per-channel level store with valid bits; unwritten entries read as zero.
// -----------------------------------------------------------------------------
`default_nettype none

module pmr_level_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pmr_pkg::lvl_ctl_t           ctl,
  input  logic [AW-1:0]               rd_addr,
  input  logic [AW-1:0]               wr_addr,
  input  logic [pmr_pkg::LEVEL_W-1:0] wr_data,
  output logic [pmr_pkg::LEVEL_W-1:0] rd_data
);
  import pmr_pkg::*;

  logic [LEVEL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  logic [LEVEL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/multichannel_peak_meter_with_release.sv */
// Sample word: S_MAP, S_MUL1, and S_MUL2 when it closes a run, which registers the result;
// read word: S_RD, then S_RDOUT; inactive-slot word: S_MAP only, then back to S_IDLE.
// One word in flight; the shared multiplier runs for each mapped sample and again at run end.
// A result waiting at the output stalls the next result, and no word is accepted meanwhile.
// Synchronous reset clears levels, mask and run state, and loads the default release factor.
// -----------------------------------------------------------------------------
// multichannel_peak_meter_with_release
// Per-channel peak meter with exponential release and level read-back.
// -----------------------------------------------------------------------------
`default_nettype none

module multichannel_peak_meter_with_release #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [3:0] active_slot, [27:4] sample_value, [32:28] physical_channel
  input  logic [pmr_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] operation
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [4:0] out_channel, [28:5] out_level
  output logic [pmr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] out_is_update
  output logic                             out_tuser,
  input  logic                             cfg_we,
  input  logic [pmr_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [pmr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pmr_pkg::*;

  localparam int LVL_AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int MAP_LIMIT = (MAX_CHANNELS < MASK_W) ? MAX_CHANNELS : MASK_W;

  state_t state_r, state_nxt;

  logic [MASK_W-1:0]      mask_r, mask_nxt;
  logic [DECAY_W-1:0]     decay_r, decay_nxt;
  logic [LEVEL_W-1:0]     peak_r, peak_nxt;
  logic [DECAY_W-1:0]     run_decay_r, run_decay_nxt;
  logic                   started_r, started_nxt;
  logic [SLOT_W-1:0]      ch_r, ch_nxt;

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [PCH_W-1:0]       out_ch_r, out_ch_nxt;
  logic [LEVEL_W-1:0]     out_lvl_r, out_lvl_nxt;
  logic                   out_upd_r, out_upd_nxt;

  logic [SLOT_W-1:0]      slot_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   last_r;
  logic [PCH_W-1:0]       pc_r;

  logic                   in_acc;
  logic                   out_free;
  logic                   map_hit;
  logic [SLOT_W-1:0]      map_ch;
  logic [LEVEL_W-1:0]     mag;
  logic [LEVEL_W-1:0]     base_peak;
  logic [LEVEL_W-1:0]     new_lvl;
  logic                   pc_in_range;

  logic                   mul_en;
  logic [DECAY_W-1:0]     mul_a, mul_b, mul_q;

  lvl_ctl_t               lvl_ctl;
  logic [LVL_AW-1:0]      lvl_rd_addr;
  logic [LEVEL_W-1:0]     lvl_rd_data;
  logic [LEVEL_W-1:0]     lvl_wr_data;

  pmr_slot_map #(.LIMIT(MAP_LIMIT)) u_map (
    .mask (mask_r),
    .slot (slot_r),
    .hit  (map_hit),
    .ch   (map_ch)
  );

  pmr_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mul_q)
  );

  pmr_level_mem #(.DEPTH(MAX_CHANNELS), .AW(LVL_AW)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (lvl_ctl),
    .rd_addr (lvl_rd_addr),
    .wr_addr (LVL_AW'(ch_r)),
    .wr_data (lvl_wr_data),
    .rd_data (lvl_rd_data)
  );

  assign in_tready   = (state_r == S_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign out_free    = !out_tvalid_r || out_tready;
  assign mag         = sample_r[SAMPLE_BITS-1] ? (~sample_r + 1'b1) : sample_r;
  assign base_peak   = started_r ? peak_r : '0;
  assign new_lvl     = (peak_r > mul_q[LEVEL_W-1:0]) ? peak_r : mul_q[LEVEL_W-1:0];
  assign pc_in_range = (int'(pc_r) < MAX_CHANNELS);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r   <= in_tdata[IN_SLOT_LSB +: SLOT_W];
      sample_r <= in_tdata[IN_SMP_LSB +: SAMPLE_BITS];
      pc_r     <= in_tdata[IN_PCH_LSB +: PCH_W];
      last_r   <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mask_r       <= '0;
      decay_r      <= DECAY_RESET;
      peak_r       <= '0;
      run_decay_r  <= ONE_Q24;
      started_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mask_r       <= mask_nxt;
      decay_r      <= decay_nxt;
      peak_r       <= peak_nxt;
      run_decay_r  <= run_decay_nxt;
      started_r    <= started_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r      <= ch_nxt;
    out_ch_r  <= out_ch_nxt;
    out_lvl_r <= out_lvl_nxt;
    out_upd_r <= out_upd_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    mask_nxt       = mask_r;
    decay_nxt      = decay_r;
    peak_nxt       = peak_r;
    run_decay_nxt  = run_decay_r;
    started_nxt    = started_r;
    ch_nxt         = ch_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_ch_nxt     = out_ch_r;
    out_lvl_nxt    = out_lvl_r;
    out_upd_nxt    = out_upd_r;
    mul_en         = 1'b0;
    mul_a          = run_decay_r;
    mul_b          = decay_r;
    lvl_ctl        = '0;
    lvl_rd_addr    = LVL_AW'(map_ch);
    lvl_wr_data    = new_lvl;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == OP_READ) ? S_RD : S_MAP;
        end
      end
      S_MAP: begin
        if (!map_hit) begin
          state_nxt = S_IDLE;
        end else begin
          peak_nxt      = (mag > base_peak) ? mag : base_peak;
          started_nxt   = 1'b1;
          mul_en        = 1'b1;
          mul_a         = started_r ? run_decay_r : ONE_Q24;
          mul_b         = decay_r;
          lvl_ctl.rd_en = 1'b1;
          ch_nxt        = map_ch;
          state_nxt     = S_MUL1;
        end
      end
      S_MUL1: begin
        run_decay_nxt = mul_q;
        if (last_r) begin
          mul_en    = 1'b1;
          mul_a     = DECAY_W'(lvl_rd_data);
          mul_b     = mul_q;
          state_nxt = S_MUL2;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL2: begin
        if (out_free) begin
          lvl_ctl.wr_en  = 1'b1;
          out_tvalid_nxt = 1'b1;
          out_ch_nxt     = PCH_W'(ch_r);
          out_lvl_nxt    = new_lvl;
          out_upd_nxt    = 1'b1;
          peak_nxt       = '0;
          run_decay_nxt  = ONE_Q24;
          started_nxt    = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_RD: begin
        lvl_ctl.rd_en = 1'b1;
        lvl_rd_addr   = LVL_AW'(pc_r);
        state_nxt     = S_RDOUT;
      end
      S_RDOUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_ch_nxt     = pc_r;
          out_lvl_nxt    = pc_in_range ? lvl_rd_data : '0;
          out_upd_nxt    = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_idx)
        REG_ACTIVE_MASK: begin
          mask_nxt      = cfg_wdata[MASK_W-1:0];
          lvl_ctl.clr   = 1'b1;
          peak_nxt      = '0;
          run_decay_nxt = ONE_Q24;
          started_nxt   = 1'b0;
        end
        REG_DECAY: begin
          decay_nxt = (cfg_wdata > ONE_Q24) ? ONE_Q24 : cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_lvl_r, out_ch_r};
  assign out_tuser  = out_upd_r;

endmodule

`default_nettype wire

/* rtl/pmr_checker.sv */
// -----------------------------------------------------------------------------
// pmr_checker
// Port-level checks on the peak meter, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pmr_checker #(
  parameter int MAX_CHANNELS = 16
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pmr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import pmr_pkg::*;

  `PMR_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_tvalid, "output valid after reset")

  `PMR_ASSERT(a_one_word_at_a_time, rst_n && in_tvalid && in_tready |=> !in_tready || !rst_n, "ready straight after accept")

  `PMR_ASSERT(a_level_in_range, out_tvalid |-> out_tdata[OUT_LVL_LSB +: LEVEL_W] <= FULL_SCALE, "level above full scale")

  `PMR_ASSERT(a_out_of_range_zero, out_tvalid && !out_tuser && (int'(out_tdata[OUT_CH_LSB +: PCH_W]) >= MAX_CHANNELS) |-> out_tdata[OUT_LVL_LSB +: LEVEL_W] == '0, "non-zero level for absent channel")

  `PMR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled output word changed")

endmodule

bind multichannel_peak_meter_with_release pmr_checker #(
  .MAX_CHANNELS(MAX_CHANNELS)
) u_pmr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

/* tb/peak_meter_checker.sv */
// -----------------------------------------------------------------------------
// peak_meter_checker
// Watches the sample, result and register ports of the peak meter. It keeps its
// own copy of the channel levels and the open run, works out the level report
// for every accepted read and run-closing active sample, and compares each
// accepted result with the oldest report still outstanding.
// -----------------------------------------------------------------------------
`default_nettype none

module peak_meter_checker #(
  parameter int NUM_CH       = 16,
  parameter int REPORT_LIMIT = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [3:0] active_slot, [27:4] sample_value, [32:28] physical_channel
  input  logic [pmr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] operation
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [4:0] out_channel, [28:5] out_level
  input  logic [pmr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] out_is_update
  input  logic                            out_tuser,
  input  logic                            cfg_we,
  input  logic [pmr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [pmr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              failures,
  output int                              pending
);
  import pmr_pkg::*;

  typedef struct packed {
    logic [PCH_W-1:0]   channel;
    logic [LEVEL_W-1:0] level;
    logic               is_update;
  } level_report_t;

  level_report_t      report_q[$];
  level_report_t      head;
  logic [LEVEL_W-1:0] level_mem [NUM_CH];
  logic [MASK_W-1:0]  mask_reg;
  logic [DECAY_W-1:0] release_reg;
  logic [LEVEL_W-1:0] run_peak_q;
  logic [DECAY_W-1:0] run_gain;
  logic               run_open;
  int                 fail_count = 0;
  int                 queued     = 0;

  assign failures = fail_count;
  assign pending  = queued;

  function automatic int slot_channel(logic [MASK_W-1:0] m, logic [SLOT_W-1:0] s);
    int seen = 0;
    for (int c = 0; c < NUM_CH && c < MASK_W; c++) begin
      if (m[c]) begin
        if (seen == s) return c;
        seen++;
      end
    end
    return -1;
  endfunction

  task automatic clear_meter();
    for (int c = 0; c < NUM_CH; c++) level_mem[c] = '0;
    run_peak_q = '0;
    run_gain   = ONE_Q24;
    run_open   = 1'b0;
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic measure_word(input logic op, input logic [SLOT_W-1:0] slot,
                              input logic [SAMPLE_BITS-1:0] smp, input logic last,
                              input logic [PCH_W-1:0] pch);
    level_report_t          rep;
    int                     ch;
    logic [LEVEL_W-1:0]     mag;
    logic [LEVEL_W-1:0]     decayed;
    logic [2*DECAY_W-1:0]   prod;
    if (op == OP_READ) begin
      rep.channel   = pch;
      rep.level     = (pch < NUM_CH) ? level_mem[pch] : '0;
      rep.is_update = 1'b0;
      report_q.push_back(rep);
      return;
    end
    ch = slot_channel(mask_reg, slot);
    if (ch < 0) return;
    mag = smp[SAMPLE_BITS-1] ? ~smp + 1'b1 : smp;
    if (!run_open) begin
      run_peak_q = '0;
      run_gain   = ONE_Q24;
      run_open   = 1'b1;
    end
    if (mag > run_peak_q) run_peak_q = mag;
    prod     = run_gain * release_reg;
    run_gain = prod[FRAC_W +: DECAY_W];
    if (!last) return;
    prod          = level_mem[ch] * run_gain;
    decayed       = prod[FRAC_W +: LEVEL_W];
    level_mem[ch] = (run_peak_q > decayed) ? run_peak_q : decayed;
    rep.channel   = PCH_W'(ch);
    rep.level     = level_mem[ch];
    rep.is_update = 1'b1;
    report_q.push_back(rep);
    run_peak_q = '0;
    run_gain   = ONE_Q24;
    run_open   = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mask_reg    = '0;
      release_reg = DECAY_RESET;
      clear_meter();
    end else begin
      if (out_tvalid && out_tready) begin
        if (report_q.size() == 0) begin
          note_failure($sformatf("unexpected result: ch %0d level %0d update %0b",
                                 out_tdata[OUT_CH_LSB +: PCH_W],
                                 out_tdata[OUT_LVL_LSB +: LEVEL_W], out_tuser));
        end else begin
          head = report_q.pop_front();
          if (out_tdata[OUT_CH_LSB +: PCH_W] !== head.channel ||
              out_tdata[OUT_LVL_LSB +: LEVEL_W] !== head.level ||
              out_tuser !== head.is_update) begin
            note_failure($sformatf(
              "mismatch: expected ch %0d level %0d upd %0b, got ch %0d level %0d upd %0b",
              head.channel, head.level, head.is_update,
              out_tdata[OUT_CH_LSB +: PCH_W], out_tdata[OUT_LVL_LSB +: LEVEL_W], out_tuser));
          end
        end
      end
      if (cfg_we) begin
        if (cfg_idx == REG_ACTIVE_MASK) begin
          mask_reg = cfg_wdata[MASK_W-1:0];
          clear_meter();
        end else if (cfg_idx == REG_DECAY) begin
          release_reg = (cfg_wdata > ONE_Q24) ? ONE_Q24 : cfg_wdata[DECAY_W-1:0];
        end
      end
      if (in_tvalid && in_tready) begin
        measure_word(in_tuser, in_tdata[IN_SLOT_LSB +: SLOT_W],
                     in_tdata[IN_SMP_LSB +: SAMPLE_BITS], in_tlast,
                     in_tdata[IN_PCH_LSB +: PCH_W]);
      end
    end
    queued = report_q.size();
  end

endmodule

`default_nettype wire

/* tb/multichannel_peak_meter_with_release_test.sv */
// -----------------------------------------------------------------------------
// multichannel_peak_meter_with_release_test
// Drives sample runs, level reads and register writes into the peak meter with
// random gaps on both sides and one long output hold-off. A checker beside the
// block predicts every level report; this module gives the verdict.
// -----------------------------------------------------------------------------
`default_nettype none

module multichannel_peak_meter_with_release_test;
  import pmr_pkg::*;

  localparam int                   CYCLE_LIMIT     = 600000;
  localparam int                   SETTLE_CYCLES   = 8;
  localparam int                   DRAIN_CYCLES    = 20;
  localparam int                   HOLD_OFF_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3     = 2'd3;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // [3:0] active_slot, [27:4] sample_value, [32:28] physical_channel
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  // [0] operation
  logic                   in_tuser   = 1'b0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [4:0] out_channel, [28:5] out_level
  logic [OUT_TDATA_W-1:0] out_tdata;
  // [0] out_is_update
  logic                   out_tuser;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx    = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int                     failures;
  int                     pending;
  int                     cycle_count  = 0;
  int                     words_counted = 0;
  int                     ready_left   = 0;
  bit                     no_idle      = 1'b0;
  bit                     hold_off_req = 1'b0;
  logic [MASK_W-1:0]      mask_now     = '0;

  multichannel_peak_meter_with_release u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  peak_meter_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .failures   (failures),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random back-pressure, one long hold-off on request
  always begin
    @(posedge clk);
    if (hold_off_req) begin
      out_tready <= 1'b0;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      hold_off_req = 1'b0;
      ready_left   = 0;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left--;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:54]: begin
          out_tready <= 1'b1;
          ready_left = $urandom_range(0, 19);
        end
        [55:91]: begin
          out_tready <= 1'b0;
          ready_left = $urandom_range(0, 2);
        end
        default: begin
          out_tready <= 1'b0;
          ready_left = $urandom_range(10, 60);
        end
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    int                     r;
    int                     k;
    logic [SAMPLE_BITS-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      case ($urandom_range(0, 3))
        0:       v = 24'h800000;
        1:       v = 24'h7FFFFF;
        2:       v = 24'h000000;
        default: v = 24'hFFFFFF;
      endcase
    end else if (r < 50) begin
      k = $urandom_range(1, 23);
      v = SAMPLE_BITS'($urandom & ((32'd1 << k) - 1));
      if ($urandom_range(0, 1) == 1) v = -v;
    end else begin
      v = SAMPLE_BITS'($urandom);
    end
    return v;
  endfunction

  task automatic send_word(input logic op, input logic [SLOT_W-1:0] slot,
                           input logic [SAMPLE_BITS-1:0] smp, input logic last,
                           input logic [PCH_W-1:0] pch);
    int                    gap;
    logic [IN_TDATA_W-1:0] word;
    gap  = pick_gap();
    word = '0;
    word[IN_SLOT_LSB +: SLOT_W]     = slot;
    word[IN_SMP_LSB +: SAMPLE_BITS] = smp;
    word[IN_PCH_LSB +: PCH_W]       = pch;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= op;
    in_tlast  <= last;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    if (op == OP_READ || slot < $countones(mask_now)) words_counted++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ACTIVE_MASK) mask_now = val[MASK_W-1:0];
  endtask

  task automatic directed_words();
    // reset mask is empty: sample dropped, read gives zero
    send_word(OP_SAMPLE, 4'd0, 24'h123456, 1'b1, 5'd0);
    send_word(OP_READ, 4'd0, 24'd0, 1'b0, 5'd0);
    write_reg(REG_ACTIVE_MASK, 25'h00FFFF);
    write_reg(REG_DECAY, ONE_Q24);
    send_word(OP_SAMPLE, 4'd0, 24'h800000, 1'b1, 5'd31);
    send_word(OP_SAMPLE, 4'd15, 24'h7FFFFF, 1'b1, 5'd0);
    send_word(OP_SAMPLE, 4'd3, 24'd5, 1'b0, 5'd0);
    send_word(OP_SAMPLE, 4'd3, 24'hFFFFF9, 1'b0, 5'd0);
    send_word(OP_SAMPLE, 4'd3, 24'd0, 1'b1, 5'd0);
    send_word(OP_READ, 4'hF, 24'hFFFFFF, 1'b1, 5'd3);
    send_word(OP_READ, 4'd0, 24'd0, 1'b0, 5'd16);
    send_word(OP_READ, 4'd0, 24'd0, 1'b0, 5'd31);
    send_word(OP_READ, 4'd0, 24'd0, 1'b0, 5'd15);
    // slot hop inside one run
    send_word(OP_SAMPLE, 4'd1, 24'd100, 1'b0, 5'd0);
    send_word(OP_SAMPLE, 4'd2, -24'sd200, 1'b1, 5'd0);
    // read in the middle of an open run
    send_word(OP_SAMPLE, 4'd0, 24'd1, 1'b0, 5'd0);
    send_word(OP_READ, 4'd0, 24'd0, 1'b0, 5'd0);
    send_word(OP_SAMPLE, 4'd0, 24'd2, 1'b1, 5'd0);
    write_reg(REG_DECAY, 25'd0);
    send_word(OP_SAMPLE, 4'd0, 24'd3, 1'b1, 5'd0);
    write_reg(REG_DECAY, 25'h1FFFFFF);
    send_word(OP_SAMPLE, 4'd0, 24'hFFFFFF, 1'b1, 5'd0);
    write_reg(REG_SPARE_2, 25'h1555555);
    write_reg(REG_SPARE_3, 25'h0AAAAAA);
    send_word(OP_SAMPLE, 4'd0, 24'd0, 1'b1, 5'd0);
    write_reg(REG_ACTIVE_MASK, 25'h008001);
    send_word(OP_SAMPLE, 4'd2, 24'h400000, 1'b1, 5'd0);
    send_word(OP_SAMPLE, 4'd1, 24'd5, 1'b1, 5'd0);
    send_word(OP_READ, 4'd0, 24'd0, 1'b0, 5'd15);
    send_word(OP_READ, 4'd0, 24'd0, 1'b0, 5'd0);
  endtask

  task automatic random_phase(input int target);
    int                start;
    int                nact;
    int                kind;
    int                len;
    int                guard;
    logic [SLOT_W-1:0] slot;
    start = words_counted;
    nact  = $countones(mask_now);
    guard = 0;
    while (words_counted - start < target && guard < 4 * target) begin
      guard++;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        send_word(OP_READ, SLOT_W'($urandom), rand_sample(), 1'($urandom), PCH_W'($urandom));
      end else if (kind < 20 || nact == 0) begin
        slot = (nact < 16) ? SLOT_W'($urandom_range(nact, 15)) : SLOT_W'($urandom);
        send_word(OP_SAMPLE, slot, rand_sample(), 1'($urandom), PCH_W'($urandom));
      end else begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        slot = SLOT_W'($urandom_range(0, nact - 1));
        for (int i = 0; i < len; i++) begin
          if (kind >= 90) slot = SLOT_W'($urandom_range(0, nact - 1));
          if ($urandom_range(0, 15) == 0)
            send_word(OP_READ, SLOT_W'($urandom), rand_sample(), 1'($urandom),
                      PCH_W'($urandom));
          send_word(OP_SAMPLE, slot, rand_sample(),
                    (kind >= 95) ? 1'($urandom) : (i == len - 1), PCH_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_words();

    write_reg(REG_ACTIVE_MASK, 25'h00FFFF);
    write_reg(REG_DECAY, DECAY_RESET);
    random_phase(180);

    write_reg(REG_ACTIVE_MASK, CFG_DATA_W'($urandom_range(1, 16'hFFFF)));
    write_reg(REG_DECAY, CFG_DATA_W'($urandom_range(0, 32'h1000000)));
    hold_off_req = 1'b1;
    random_phase(150);

    write_reg(REG_ACTIVE_MASK, 25'h000001);
    write_reg(REG_DECAY, 25'd0);
    no_idle = 1'b1;
    random_phase(100);
    no_idle = 1'b0;

    write_reg(REG_ACTIVE_MASK, 25'h008000);
    write_reg(REG_DECAY, 25'h1FFFFFF);
    random_phase(100);

    write_reg(REG_ACTIVE_MASK, 25'h000000);
    write_reg(REG_DECAY, CFG_DATA_W'($urandom_range(0, 32'h1000000)));
    random_phase(40);

    write_reg(REG_ACTIVE_MASK, 25'h00A5A5);
    write_reg(REG_DECAY, ONE_Q24);
    random_phase(150);

    write_reg(REG_ACTIVE_MASK, CFG_DATA_W'($urandom_range(1, 16'hFFFF)));
    write_reg(REG_DECAY, CFG_DATA_W'($urandom_range(16700000, 32'h1000000)));
    random_phase(150);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
